[design/pmc_pkg.sv]
// ----------------------------------------------------------------------------
// Polynomial multiply core package
// Request and response payloads, command codes and the types that link the
// cells of the convolution row.
// ----------------------------------------------------------------------------
package pmc_pkg;

   // Fixed field widths of the request and response payloads.
   localparam int REQ_COEFF_WIDTH = 32;
   localparam int ACC_WIDTH       = 64;

   // Request command codes.
   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_STREAM = 1'b1;

   typedef struct packed {
      logic                               cmd;
      logic signed [REQ_COEFF_WIDTH-1:0]  coeff;
      logic                               last_in;
   } req_type;

   typedef struct packed {
      logic signed [ACC_WIDTH-1:0] product_coeff;
      logic                        last_out;
      logic                        overflow_flag;
   } rsp_type;

   // Values one cell hands down to its lower neighbor.
   typedef struct packed {
      logic [ACC_WIDTH-1:0] acc;   // held partial sum plus held product
      logic [ACC_WIDTH-1:0] sum;   // held partial sum alone
   } cell_link_type;

   // Controls broadcast to every cell of the row.
   typedef struct packed {
      logic                              clear_b;  // start a new second polynomial
      logic                              capture;  // take the product of a new request
      logic                              advance;  // accumulate and shift the row
      logic                              flush;    // shift the row without adding
      logic [REQ_COEFF_WIDTH-1:0]        coeff;    // coefficient of the request
   } cell_ctrl_type;

endpackage

[design/pmc_cell.sv]
// ----------------------------------------------------------------------------
// Polynomial multiply cell
// One tap of the transposed convolution row: holds one coefficient of the
// second polynomial, the registered product with the streamed coefficient and
// one partial sum that moves one place down the row on every step.
// ----------------------------------------------------------------------------
module pmc_cell #(
   parameter int COEFF_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pmc_pkg::cell_ctrl_type ctrl,
   input  logic                   load_sel,
   input  pmc_pkg::cell_link_type up_link,
   output pmc_pkg::cell_link_type down_link
);
   import pmc_pkg::*;

   logic signed [COEFF_WIDTH-1:0]   b_ff;
   logic signed [COEFF_WIDTH-1:0]   a_coeff;
   logic signed [2*COEFF_WIDTH-1:0] prod_full;
   logic [ACC_WIDTH-1:0]            prod_ff;
   logic [ACC_WIDTH-1:0]            sum_ff;

   // Streamed coefficient, narrowed to the working width and multiplied.
   assign a_coeff   = ctrl.coeff[COEFF_WIDTH-1:0];
   assign prod_full = a_coeff * b_ff;

   // Stored coefficient of the second polynomial.
   always_ff @(posedge clock) begin
      if (reset) begin
         b_ff <= '0;
      end else if (load_sel) begin
         b_ff <= ctrl.coeff[COEFF_WIDTH-1:0];
      end else if (ctrl.clear_b) begin
         b_ff <= '0;
      end
   end

   // Product register, sign-extended to the accumulator width.
   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         prod_ff <= ACC_WIDTH'(prod_full);
      end
   end

   // Partial sum moves down from the upper neighbor.
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (ctrl.advance) begin
         sum_ff <= up_link.acc;
      end else if (ctrl.flush) begin
         sum_ff <= up_link.sum;
      end
   end

   assign down_link.acc = sum_ff + prod_ff;
   assign down_link.sum = sum_ff;

endmodule

[design/polynomial_multiply_core.sv]
// Streamed products are registered in the cells, then in the response register.
// Throughput: one request, stream or load, per cycle while responses do not
// stall and no flush runs; the request marked last is followed by a flush of one
// response per stored second-polynomial coefficient, during which the row of
// cells shifts and no further product enters it. Loads give no response.
// Reset clears the stored coefficients, the partial sums and all control state.
// ----------------------------------------------------------------------------
// Polynomial multiply core
// Integer polynomial product as a systolic transposed convolution: loads fill
// a row of cells with the second polynomial, streamed coefficients of the
// first polynomial each produce one product coefficient, and the last one
// flushes the rest of the row.
// ----------------------------------------------------------------------------
module polynomial_multiply_core #(
   parameter int MAX_TERMS   = 16,
   parameter int COEFF_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pmc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pmc_pkg::rsp_type rsp_data
);
   import pmc_pkg::*;

   localparam int CNT_WIDTH = $clog2(MAX_TERMS + 1);
   localparam logic [CNT_WIDTH-1:0] CNT_MAX = CNT_WIDTH'(MAX_TERMS);
   localparam logic [CNT_WIDTH-1:0] CNT_ONE = CNT_WIDTH'(1);

   // Input side state.
   logic [CNT_WIDTH-1:0] count_ff, count_in;
   logic                 done_ff, done_in;
   logic                 drop_ff, drop_in;

   // Product stage.
   logic                 p_valid_ff;
   logic                 p_last_ff;
   logic                 p_flag_ff;
   logic [CNT_WIDTH-1:0] p_count_ff;

   // Flush and response.
   logic [CNT_WIDTH-1:0] flush_left_ff, flush_left_in;
   logic                 flush_flag_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;

   logic          req_accept;
   logic          capture;
   logic          load_ok;
   logic          out_free;
   logic          flushing;
   logic          do_acc;
   logic          do_flush;
   cell_ctrl_type ctrl;
   cell_link_type links [MAX_TERMS+1];
   logic [MAX_TERMS-1:0] load_sel;

   // Handshake and step decisions.
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign flushing   = (flush_left_ff != '0);
   assign do_flush   = flushing && out_free;
   assign do_acc     = !flushing && p_valid_ff && out_free;
   assign req_ready  = !p_valid_ff || do_acc;
   assign req_accept = req_valid && req_ready;
   assign capture    = req_accept && (req_data.cmd == CMD_STREAM);
   assign load_ok    = req_accept && (req_data.cmd == CMD_LOAD);

   // Load bookkeeping: a load after a finished product starts a new polynomial.
   always_comb begin
      count_in = count_ff;
      drop_in  = drop_ff;
      done_in  = done_ff;
      if (load_ok) begin
         done_in = 1'b0;
         if (done_ff) begin
            count_in = CNT_ONE;
            drop_in  = 1'b0;
         end else if (count_ff < CNT_MAX) begin
            count_in = count_ff + CNT_ONE;
         end else begin
            drop_in = 1'b1;
         end
      end else if (capture) begin
         done_in = req_data.last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         drop_ff  <= 1'b0;
         done_ff  <= 1'b1;
      end else begin
         count_ff <= count_in;
         drop_ff  <= drop_in;
         done_ff  <= done_in;
      end
   end

   // Broadcast controls and per-cell load selects.
   assign ctrl.clear_b = load_ok && done_ff;
   assign ctrl.capture = capture;
   assign ctrl.advance = do_acc;
   assign ctrl.flush   = do_flush;
   assign ctrl.coeff   = req_data.coeff;

   always_comb begin
      for (int j = 0; j < MAX_TERMS; j++) begin
         if (done_ff) begin
            load_sel[j] = load_ok && (j == 0);
         end else begin
            load_sel[j] = load_ok && (count_ff == CNT_WIDTH'(j));
         end
      end
   end

   // Row of cells; the top cell takes zeros from above.
   assign links[MAX_TERMS] = '0;

   for (genvar j = 0; j < MAX_TERMS; j++) begin : g_cell
      pmc_cell #(
         .COEFF_WIDTH (COEFF_WIDTH)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .load_sel  (load_sel[j]),
         .up_link   (links[j+1]),
         .down_link (links[j])
      );
   end

   // Product stage control: the request's tags travel with its products.
   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (capture) begin
         p_valid_ff <= 1'b1;
      end else if (do_acc) begin
         p_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         p_last_ff  <= req_data.last_in;
         p_flag_ff  <= drop_ff;
         p_count_ff <= count_ff;
      end
   end

   // Flush counter, loaded by a last request over a non-empty polynomial.
   always_comb begin
      flush_left_in = flush_left_ff;
      if (do_acc && p_last_ff) begin
         flush_left_in = p_count_ff;
      end else if (do_flush) begin
         flush_left_in = flush_left_ff - CNT_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flush_left_ff <= '0;
      end else begin
         flush_left_ff <= flush_left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_acc && p_last_ff) begin
         flush_flag_ff <= p_flag_ff;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (do_acc || do_flush) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (do_acc) begin
         rsp_ff.product_coeff <= links[0].acc;
         rsp_ff.last_out      <= p_last_ff && (p_count_ff == '0);
         rsp_ff.overflow_flag <= p_flag_ff;
      end else if (do_flush) begin
         rsp_ff.product_coeff <= links[0].sum;
         rsp_ff.last_out      <= (flush_left_ff == CNT_ONE);
         rsp_ff.overflow_flag <= flush_flag_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The stored term count never passes the row length.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_MAX)
      else $error("term count beyond row length");

   // A dropped load can only happen with a full row.
   assert property (@(posedge clock) disable iff (reset)
      drop_ff |-> (count_ff == CNT_MAX))
      else $error("drop flag set with room left in the row");

   // After the final flush step the bottom partial sum is cleared.
   assert property (@(posedge clock) disable iff (reset)
      (do_flush && (flush_left_ff == CNT_ONE)) |=> (links[0].sum == '0))
      else $error("row not clear after flush");

endmodule

[verif/polynomial_multiply_core_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Polynomial multiply core checker
// Watches the request and response channels. Every accepted request runs
// through a local model of the convolution row, which queues the product
// coefficients it should yield. Every accepted response is compared field by
// field with the oldest queued product coefficient.
// ----------------------------------------------------------------------------
module polynomial_multiply_core_checker #(
   parameter int MAX_TERMS   = 16,
   parameter int COEFF_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  pmc_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  pmc_pkg::rsp_type rsp_data,
   output int               mismatch_count,
   output int               pending_products
);
   import pmc_pkg::*;

   // Local copy of the second polynomial and of the row of partial sums.
   logic [ACC_WIDTH-1:0] b_coeffs [MAX_TERMS];
   logic [ACC_WIDTH-1:0] row_sums [MAX_TERMS];
   int                   b_count;
   bit                   product_done;
   bit                   load_dropped;

   // Product coefficients that the block still owes, oldest first.
   rsp_type expected_products [$];

   // Sign-extend the low COEFF_WIDTH bits of a request coefficient.
   function automatic logic [ACC_WIDTH-1:0] widen_coeff(input logic [REQ_COEFF_WIDTH-1:0] raw);
      return {{(ACC_WIDTH-COEFF_WIDTH){raw[COEFF_WIDTH-1]}}, raw[COEFF_WIDTH-1:0]};
   endfunction

   function automatic rsp_type make_product(input logic [ACC_WIDTH-1:0] value, input bit is_last);
      rsp_type rsp;
      rsp.product_coeff = value;
      rsp.last_out      = is_last;
      rsp.overflow_flag = load_dropped;
      return rsp;
   endfunction

   // Append one expected product coefficient behind the ones already owed.
   function automatic void queue_product(input logic [ACC_WIDTH-1:0] value, input bit is_last);
      expected_products.insert(expected_products.size(), make_product(value, is_last));
   endfunction

   // Advance the model by one request and queue the products it yields.
   task automatic convolve_request(input req_type item);
      logic [ACC_WIDTH-1:0] coeff_value;
      logic [ACC_WIDTH-1:0] lowest;
      coeff_value = widen_coeff(item.coeff);
      if (item.cmd == CMD_LOAD) begin
         // The first load after a finished product starts a new polynomial.
         if (product_done) begin
            foreach (b_coeffs[j]) b_coeffs[j] = '0;
            b_count      = 0;
            load_dropped = 1'b0;
            product_done = 1'b0;
         end
         if (b_count < MAX_TERMS) begin
            b_coeffs[b_count] = coeff_value;
            b_count++;
         end else begin
            load_dropped = 1'b1;
         end
      end else begin
         // Accumulate into the row, emit the lowest sum and shift down.
         for (int j = 0; j < b_count; j++) begin
            row_sums[j] = row_sums[j] + coeff_value * b_coeffs[j];
         end
         lowest = row_sums[0];
         for (int j = 0; j + 1 < MAX_TERMS; j++) begin
            row_sums[j] = row_sums[j + 1];
         end
         row_sums[MAX_TERMS-1] = '0;
         if (!item.last_in) begin
            product_done = 1'b0;
            queue_product(lowest, 1'b0);
         end else begin
            // The last request flushes the rest of the row.
            queue_product(lowest, b_count == 0);
            for (int j = 0; j < b_count; j++) begin
               queue_product(row_sums[j], j + 1 == b_count);
            end
            foreach (row_sums[j]) row_sums[j] = '0;
            product_done = 1'b1;
         end
      end
   endtask

   // Responses are checked before the request of the same edge is modeled;
   // the latency of the block keeps the two apart.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         foreach (b_coeffs[j]) b_coeffs[j] = '0;
         foreach (row_sums[j]) row_sums[j] = '0;
         b_count      = 0;
         product_done = 1'b1;
         load_dropped = 1'b0;
         expected_products.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_products.size() == 0) begin
               $display("%0t: unexpected response: expected none, actual %p", $time, rsp_data);
               mismatch_count++;
            end else begin
               want = expected_products.pop_front();
               if (rsp_data.product_coeff !== want.product_coeff) begin
                  $display("%0t: product_coeff mismatch: expected %0d, actual %0d",
                           $time, want.product_coeff, rsp_data.product_coeff);
                  mismatch_count++;
               end
               if (rsp_data.last_out !== want.last_out) begin
                  $display("%0t: last_out mismatch: expected %b, actual %b",
                           $time, want.last_out, rsp_data.last_out);
                  mismatch_count++;
               end
               if (rsp_data.overflow_flag !== want.overflow_flag) begin
                  $display("%0t: overflow_flag mismatch: expected %b, actual %b",
                           $time, want.overflow_flag, rsp_data.overflow_flag);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            convolve_request(req_data);
         end
      end
      pending_products = expected_products.size();
   end

endmodule

[verif/polynomial_multiply_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Polynomial multiply core testbench
// Drives directed corner cases and then random products of small and full
// sized polynomials through the core, with random gaps on both channels, a
// long response hold-off and pauses until the core drains. The checker
// beside the core predicts and compares every response.
// ----------------------------------------------------------------------------
module polynomial_multiply_core_tb;
   import pmc_pkg::*;

   localparam int  MAX_TERMS       = 16;
   localparam int  COEFF_WIDTH     = 32;
   localparam int  HOLD_OFF_CYCLES = 150;
   localparam int  SETTLE_CYCLES   = 20;
   localparam int  PHASE_REQUESTS  = 70;
   localparam time TIMEOUT_NS      = 2_000_000;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   int          mismatch_count;
   int          pending_products;
   int          requests_sent = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   bit          hold_off_req  = 1'b0;

   polynomial_multiply_core #(
      .MAX_TERMS   (MAX_TERMS),
      .COEFF_WIDTH (COEFF_WIDTH)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   polynomial_multiply_core_checker #(
      .MAX_TERMS   (MAX_TERMS),
      .COEFF_WIDTH (COEFF_WIDTH)
   ) product_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .mismatch_count   (mismatch_count),
      .pending_products (pending_products)
   );

   always #1 clock = ~clock;

   // The run must never hang.
   initial begin
      #(TIMEOUT_NS);
      $display("FAIL polynomial_multiply_core");
      $finish;
   end

   // Response side: random stalls, plus one long hold-off on request.
   initial begin
      bit hold_off_taken;
      hold_off_taken = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req && !hold_off_taken) begin
            hold_off_taken = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Coefficients lean toward the extremes, zero and small values.
   function automatic logic [REQ_COEFF_WIDTH-1:0] pick_coeff();
      case ($urandom_range(7))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return '1;
         3:       return '0;
         4:       return $urandom_range(16) - 8;
         default: return $urandom;
      endcase
   endfunction

   // Offer one request at a falling edge and hold it until accepted.
   task automatic send_request(input logic cmd, input logic [REQ_COEFF_WIDTH-1:0] coeff,
                               input logic last_in);
      req_type item;
      item.cmd     = cmd;
      item.coeff   = coeff;
      item.last_in = last_in;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      requests_sent++;
   endtask

   // Stop offering requests until every product coefficient has come back.
   task automatic drain_products();
      req_valid <= 1'b0;
      wait (pending_products == 0);
      @(negedge clock);
   endtask

   // One product: a fresh second polynomial (none keeps the held one), then
   // the first polynomial with an occasional load slipped into the stream.
   task automatic send_product(input int b_terms, input int a_terms);
      for (int j = 0; j < b_terms; j++) begin
         send_request(CMD_LOAD, pick_coeff(), 1'($urandom_range(1)));
      end
      for (int j = 0; j < a_terms; j++) begin
         if ($urandom_range(9) == 0) begin
            send_request(CMD_LOAD, pick_coeff(), 1'($urandom_range(1)));
         end
         send_request(CMD_STREAM, pick_coeff(), j == a_terms - 1);
      end
   endtask

   task automatic run_random_phase(input int request_target);
      int first_request;
      first_request = requests_sent;
      while (requests_sent - first_request < request_target) begin
         case ($urandom_range(9))
            0:       send_request(1'($urandom_range(1)), pick_coeff(),
                                  1'($urandom_range(1)));
            1:       send_product(0, $urandom_range(1, 6));
            2:       send_product($urandom_range(MAX_TERMS, MAX_TERMS + 3), $urandom_range(1, 4));
            default: send_product($urandom_range(1, 8), $urandom_range(1, 6));
         endcase
      end
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      send_idle_pct = 7;
      recv_idle_pct = 82;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // Nothing loaded yet: the stream yields zeros only.
      send_request(CMD_STREAM, 32'd5, 1'b0);
      send_request(CMD_STREAM, 32'h8000_0000, 1'b1);

      // Extreme coefficients on both sides; last_in on a load is ignored.
      send_request(CMD_LOAD, 32'h7FFF_FFFF, 1'b1);
      send_request(CMD_LOAD, 32'h8000_0000, 1'b0);
      send_request(CMD_LOAD, 32'hFFFF_FFFF, 1'b0);
      send_request(CMD_STREAM, 32'h8000_0000, 1'b0);
      send_request(CMD_STREAM, 32'h7FFF_FFFF, 1'b0);
      send_request(CMD_STREAM, 32'hFFFF_FFFF, 1'b1);

      // A new stream with no load reuses the held polynomial.
      send_request(CMD_STREAM, 32'h0, 1'b0);
      send_request(CMD_STREAM, 32'h8000_0000, 1'b1);

      // Loads in the middle of a stream extend the polynomial and the flush.
      send_request(CMD_LOAD, 32'd3, 1'b0);
      send_request(CMD_STREAM, 32'd7, 1'b0);
      send_request(CMD_LOAD, -32'sd2, 1'b0);
      send_request(CMD_STREAM, 32'h7FFF_FFFF, 1'b0);
      send_request(CMD_LOAD, 32'h8000_0000, 1'b0);
      send_request(CMD_STREAM, 32'h8000_0000, 1'b1);

      // Single-term product.
      send_request(CMD_LOAD, 32'hFFFF_FFFF, 1'b0);
      send_request(CMD_STREAM, 32'hFFFF_FFFF, 1'b1);

      run_random_phase(PHASE_REQUESTS);
      drain_products();

      send_idle_pct = 82;
      recv_idle_pct = 7;
      run_random_phase(PHASE_REQUESTS);
      drain_products();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random_phase(PHASE_REQUESTS);
      drain_products();

      // Long response hold-off while a full-size product keeps streaming.
      @(posedge clock);
      hold_off_req = 1'b1;
      @(negedge clock);
      send_product(MAX_TERMS, 40);
      drain_products();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_products == 0) begin
         $display("PASS polynomial_multiply_core");
      end else begin
         $display("FAIL polynomial_multiply_core");
      end
      $finish;
   end

endmodule
